// File: design/sem_pkg.sv
package sem_pkg;

    localparam int PIX_W = 24;
    localparam int CFG_W = 12;
    localparam int COL_W = 13;
    localparam int ROW_W = 13;
    localparam int TOT_W = 23;
    localparam int POS_W = 24;

    localparam logic CMD_DRAIN        = 1'b1;
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_edge;
        logic [7:0] green_edge;
        logic [7:0] blue_edge;
        logic       last_of_frame;
    } t_pix_out;

    // one classified item on its way from front to back
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [COL_W-1:0] addr;
        logic             produce;
        logic             top;
        logic             bottom;
        logic             left;
        logic             right;
        logic             last;
    } t_work;

endpackage

// File: design/sem_ram.sv
module sem_ram
#(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
)
(
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/sem_front.sv
module sem_front import sem_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_pix_in          i_in_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_push,
    output t_work            o_work,
    input  logic             i_full
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = AW + 1;
    localparam int DCW = $clog2(TOT_W + 1);

    logic [10:0]      r_width;
    logic [11:0]      r_height;
    logic [TOT_W-1:0] r_total;
    logic [AW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [TOT_W-1:0] r_emit;
    logic [11:0]      r_orow;
    logic [AW-1:0]    r_ocol;
    logic             r_busy;
    logic [DCW-1:0]   r_div_cnt;
    logic [10:0]      r_rem;
    logic [TOT_W-1:0] r_quo;

    logic [10:0]      w_eff;
    logic [11:0]      h_eff;
    logic             pre_wrap;
    logic [AW-1:0]    col;
    logic [ROW_W-1:0] row;
    logic [TOT_W-1:0] emit;
    logic [11:0]      orow;
    logic [AW-1:0]    ocol;
    logic [POS_W-1:0] pos;
    logic             beyond;
    logic             produce;
    logic [TOT_W-1:0] n_emit;
    logic [CW-1:0]    col_inc;
    logic [CW-1:0]    ocol_inc;
    logic [11:0]      div_t;
    logic             div_ge;
    logic             cfg_we;

    always_comb begin
        if (r_width == 11'd0) begin
            w_eff = 11'd1;
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_eff = 11'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        h_eff = (r_height == 12'd0) ? 12'd1 : r_height;
    end

    // start of a step: a frame whose results are all out begins anew
    always_comb begin
        pre_wrap = r_emit >= r_total;
        col  = pre_wrap ? '0 : r_col;
        row  = pre_wrap ? '0 : r_row;
        emit = pre_wrap ? '0 : r_emit;
        orow = pre_wrap ? '0 : r_orow;
        ocol = pre_wrap ? '0 : r_ocol;
        pos = POS_W'({11'd0, row} * {13'd0, w_eff}) + POS_W'(col);
        beyond  = pos >= POS_W'(r_total);
        produce = pos >= (POS_W'(w_eff) + POS_W'(1));
        n_emit  = emit + TOT_W'(produce);
        col_inc  = CW'(col) + CW'(1);
        ocol_inc = CW'(ocol) + CW'(1);
    end

    always_comb begin
        o_work.pix = (i_in_data.command == CMD_DRAIN || beyond) ? '0 :
                     {i_in_data.blue_in, i_in_data.green_in, i_in_data.red_in};
        o_work.addr    = COL_W'(col);
        o_work.produce = produce;
        o_work.top     = orow == 12'd0;
        o_work.bottom  = orow == (h_eff - 12'd1);
        o_work.left    = ocol == '0;
        o_work.right   = 14'(ocol) == (14'(w_eff) - 14'd1);
        o_work.last    = emit == (r_total - TOT_W'(1));
    end

    assign o_in_ready  = !r_busy && !i_full;
    assign o_push      = i_in_valid && o_in_ready;
    assign o_cfg_ready = !r_busy;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // restoring divide of the result count by the width, one bit a cycle
    assign div_t  = {r_rem, r_quo[TOT_W-1]};
    assign div_ge = div_t >= {1'b0, w_eff};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= 11'd640;
            r_height  <= 12'd480;
            r_total   <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_emit    <= '0;
            r_orow    <= '0;
            r_ocol    <= '0;
            r_busy    <= 1'b1;
            r_div_cnt <= '0;
            r_rem     <= '0;
            r_quo     <= '0;
        end else if (r_busy) begin
            r_total <= TOT_W'({12'd0, w_eff} * {11'd0, h_eff});
            if (r_div_cnt == DCW'(TOT_W)) begin
                r_busy <= 1'b0;
                r_orow <= r_quo[11:0];
                r_ocol <= AW'(r_rem);
            end else begin
                r_div_cnt <= r_div_cnt + DCW'(1);
                r_rem     <= div_ge ? 11'(div_t - {1'b0, w_eff}) : div_t[10:0];
                r_quo     <= {r_quo[TOT_W-2:0], div_ge};
            end
        end else begin
            if (cfg_we) begin
                if (i_cfg_index == REG_FRAME_WIDTH) begin
                    r_width <= i_cfg_data[10:0];
                end else begin
                    r_height <= i_cfg_data;
                end
                r_busy    <= 1'b1;
                r_div_cnt <= '0;
                r_rem     <= '0;
                r_quo     <= r_emit;
            end
            if (o_push) begin
                if (n_emit >= r_total) begin
                    r_col  <= '0;
                    r_row  <= '0;
                    r_emit <= '0;
                    r_orow <= '0;
                    r_ocol <= '0;
                end else begin
                    r_emit <= n_emit;
                    if (col_inc >= CW'(w_eff)) begin
                        r_col <= '0;
                        r_row <= row + ROW_W'(1);
                    end else begin
                        r_col <= col_inc[AW-1:0];
                        r_row <= row;
                    end
                    if (produce) begin
                        if (ocol_inc >= CW'(w_eff)) begin
                            r_ocol <= '0;
                            r_orow <= orow + 12'd1;
                        end else begin
                            r_ocol <= ocol_inc[AW-1:0];
                            r_orow <= orow;
                        end
                    end else begin
                        r_ocol <= ocol;
                        r_orow <= orow;
                    end
                end
            end
        end
    end

    a_ocol_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (14'(r_ocol) < 14'(w_eff)))
        else $error("output column beyond row width");
    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_div_cnt == DCW'(TOT_W)) |=> !r_busy)
        else $error("divide sequence did not finish");

endmodule

// File: design/sem_queue.sv
module sem_queue import sem_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    output logic  o_full,
    input  logic  i_pop,
    output t_work o_work,
    output logic  o_empty
);

    localparam int DEPTH = 4;
    localparam int PW = $clog2(DEPTH);

    t_work         r_slot [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [PW:0]   r_count;

    assign o_full  = r_count == (PW+1)'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_work  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            r_count <= r_count + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");

endmodule

// File: design/sem_back.sv
module sem_back import sem_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_empty,
    input  t_work    i_work,
    output logic     o_pop,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_pix_out o_out_data
);

    localparam int AW = $clog2(MAX_WIDTH);

    typedef logic [2:0][PIX_W-1:0] t_col3;

    // partial square root: remainder, root so far, saturation flag
    typedef struct packed {
        logic [16:0] rem;
        logic [16:0] res;
        logic        sat;
    } t_sqrt;

    logic                 en;
    logic [2*PIX_W-1:0]   ram_rdata;
    logic [2*PIX_W-1:0]   rd;
    logic [PIX_W-1:0]     up;
    logic [PIX_W-1:0]     lo;
    logic                 r_s2_valid;
    t_work                r_s2;
    logic                 r_fwd;
    logic [2*PIX_W-1:0]   r_fwd_data;
    t_col3                r_win [3];
    t_col3                n_win [3];
    logic signed [10:0]   gx [3];
    logic signed [10:0]   gy [3];
    logic                 r_s3_valid;
    logic                 r_s3_last;
    logic signed [10:0]   r_gx [3];
    logic signed [10:0]   r_gy [3];
    logic                 r_s4_valid;
    logic                 r_s4_last;
    logic [20:0]          r_sq [3];
    t_sqrt                part [3];
    t_sqrt                fin [3];
    logic                 r_s5_valid;
    logic                 r_s5_last;
    t_sqrt                r_part [3];
    logic                 r_out_valid;
    t_pix_out             r_out;

    // four digits of the restoring square root, starting at first_bit
    function automatic t_sqrt f_sqrt_half(input t_sqrt a, input logic [16:0] first_bit);
        t_sqrt       q;
        logic [16:0] bitv;
        q    = a;
        bitv = first_bit;
        for (int i = 0; i < 4; i++) begin
            if (q.rem >= q.res + bitv) begin
                q.rem = q.rem - (q.res + bitv);
                q.res = (q.res >> 1) + bitv;
            end else begin
                q.res = q.res >> 1;
            end
            bitv = bitv >> 2;
        end
        return q;
    endfunction

    function automatic logic [7:0] f_round(input t_sqrt q);
        logic [7:0] n;
        n = q.res[7:0];
        if (q.rem > q.res) begin
            n = n + 8'd1;
        end
        if (q.sat) begin
            n = 8'd255;
        end
        return n;
    endfunction

    assign en    = !r_out_valid || i_out_ready;
    assign o_pop = en && !i_empty;

    // each entry holds {upper row, lower row} for one column
    sem_ram #(.WIDTH(2*PIX_W), .DEPTH(MAX_WIDTH)) u_lines (
        .i_clk   (i_clk),
        .i_we    (en && r_s2_valid),
        .i_waddr (r_s2.addr[AW-1:0]),
        .i_wdata ({lo, r_s2.pix}),
        .i_re    (o_pop),
        .i_raddr (i_work.addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // back-to-back on one column (width 1) reads what is being written
    assign rd = r_fwd ? r_fwd_data : ram_rdata;
    assign up = rd[2*PIX_W-1:PIX_W];
    assign lo = rd[PIX_W-1:0];

    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = {r_s2.pix, lo, up};
    end

    always_comb begin
        logic [7:0] v [3][3];
        logic [9:0] a;
        logic [9:0] b;
        for (int ch = 0; ch < 3; ch++) begin
            for (int dc = 0; dc < 3; dc++) begin
                for (int dr = 0; dr < 3; dr++) begin
                    if ((dr == 0 && r_s2.top) || (dr == 2 && r_s2.bottom) ||
                        (dc == 0 && r_s2.left) || (dc == 2 && r_s2.right)) begin
                        v[dc][dr] = 8'd0;
                    end else begin
                        v[dc][dr] = n_win[dc][dr][8*ch +: 8];
                    end
                end
            end
            a = 10'(v[2][0]) + {1'b0, v[2][1], 1'b0} + 10'(v[2][2]);
            b = 10'(v[0][0]) + {1'b0, v[0][1], 1'b0} + 10'(v[0][2]);
            gx[ch] = $signed({1'b0, a}) - $signed({1'b0, b});
            a = 10'(v[0][2]) + {1'b0, v[1][2], 1'b0} + 10'(v[2][2]);
            b = 10'(v[0][0]) + {1'b0, v[1][0], 1'b0} + 10'(v[2][0]);
            gy[ch] = $signed({1'b0, a}) - $signed({1'b0, b});
        end
    end

    // square root split over two stages, upper and lower four digits
    always_comb begin
        t_sqrt seed;
        for (int ch = 0; ch < 3; ch++) begin
            seed.rem = r_sq[ch][16:0];
            seed.res = '0;
            seed.sat = r_sq[ch] > 21'd65280;
            part[ch] = f_sqrt_half(seed, 17'h4000);
            fin[ch]  = f_sqrt_half(r_part[ch], 17'h0040);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < 3; c++) begin
                r_win[c] <= '0;
            end
        end else if (en) begin
            r_s2_valid <= o_pop;
            r_fwd      <= o_pop && r_s2_valid && (i_work.addr == r_s2.addr);
            if (r_s2_valid) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[c] <= n_win[c];
                end
            end
            r_s3_valid  <= r_s2_valid && r_s2.produce;
            r_s4_valid  <= r_s3_valid;
            r_s5_valid  <= r_s4_valid;
            r_out_valid <= r_s5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (o_pop) begin
                r_s2 <= i_work;
            end
            r_fwd_data <= {lo, r_s2.pix};
            r_s3_last  <= r_s2.last;
            r_s4_last  <= r_s3_last;
            r_s5_last  <= r_s4_last;
            for (int ch = 0; ch < 3; ch++) begin
                r_gx[ch]   <= gx[ch];
                r_gy[ch]   <= gy[ch];
                r_sq[ch]   <= 21'(r_gx[ch] * r_gx[ch]) + 21'(r_gy[ch] * r_gy[ch]);
                r_part[ch] <= part[ch];
            end
            r_out.red_edge      <= f_round(fin[0]);
            r_out.green_edge    <= f_round(fin[1]);
            r_out.blue_edge     <= f_round(fin[2]);
            r_out.last_of_frame <= r_s5_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_fwd_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s2_valid)
        else $error("forwarded line data without an item");

endmodule

// File: design/sobel_edge_magnitude_rgb.sv
// channel | direction | handshake                   | payload
// in      | input     | i_in_valid / o_in_ready     | i_in_data  (t_pix_in)
// out     | output    | o_out_valid / i_out_ready   | o_out_data (t_pix_out)
// cfg     | input     | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the front is not busy and the output is not stalled.
// Throughput is set by the single line-store RAM port pair, one read and one write per item.
// After reset and after every register write the front is busy recomputing the
// frame size and output position (bit-serial divide); no item is taken meanwhile.
// A stalled output freezes the back pipeline; the 4-entry queue lets the front keep going.
module sobel_edge_magnitude_rgb import sem_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_pix_in          i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_pix_out         o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic  push;
    logic  full;
    logic  pop;
    logic  empty;
    t_work work_in;
    t_work work_out;

    sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_work      (work_in),
        .i_full      (full)
    );

    sem_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (work_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_work  (work_out),
        .o_empty (empty)
    );

    sem_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_work      (work_out),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
